// ===== hdl/mrd_pkg.sv =====
// Package for the Modbus RTU response deframer.
// Holds the function codes, frame kinds, parser phases, the queue entry type
// and the CRC-16 byte update. Depends on nothing.
`default_nettype none

package mrd_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FN_READ      = 8'h03;
   localparam logic [7:0] FN_WRITE     = 8'h06;
   localparam logic [7:0] FN_READ_EXC  = 8'h83;
   localparam logic [7:0] FN_WRITE_EXC = 8'h86;

   localparam logic [8:0] WRITE_FRAME_LEN = 9'd8;
   localparam logic [8:0] EXC_FRAME_LEN   = 9'd5;
   localparam logic [8:0] READ_OVERHEAD   = 9'd5;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_EMPTY = 2'd0,
      PH_ADDR  = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_WRITE_ACK  = 3'd0,
      KIND_READ_VALUE = 3'd1,
      KIND_READ_FMT   = 3'd2,
      KIND_EXCEPTION  = 3'd3,
      KIND_CRC_ERROR  = 3'd4
   } kind_type;

   // Summary of one complete frame, as the parser hands it to the queue.
   typedef struct packed {
      logic        crc_ok;
      logic [7:0]  address;
      logic [7:0]  func;
      logic [7:0]  count;
      logic [15:0] data;
   } frame_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mrd_if.sv =====
// Channel interfaces of the Modbus RTU response deframer.
// One interface for received bytes and one for decoded frames; no dependencies.
`default_nettype none

interface mrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_kind;
   logic [7:0]  slave_address;
   logic [7:0]  function_code;
   logic [15:0] register_value;
   logic [7:0]  exception_code;

   modport source (output valid, output frame_kind, output slave_address,
                   output function_code, output register_value,
                   output exception_code, input ready);
   modport sink (input valid, input frame_kind, input slave_address,
                 input function_code, input register_value,
                 input exception_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/mrd_front.sv =====
// Front part of the deframer: accepts bytes, tracks the frame and its CRC.
// Pushes one frame summary per complete frame. Depends on mrd_pkg.
`default_nettype none

module mrd_front
   import mrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      byte_valid,
   input  wire logic [7:0] byte_data,
   output logic           byte_ready,
   input  wire logic      queue_full,
   output logic           push,
   output frame_type      frame
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [8:0]  len_ff, len_in;
   logic [8:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] data_ff, data_in;

   logic        accept;
   logic        supported;
   logic        done;
   logic [15:0] crc_next;
   logic [8:0]  idx_inc;
   logic [8:0]  len_eff;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign supported  = (byte_data == FN_READ) || (byte_data == FN_WRITE) ||
                       (byte_data == FN_READ_EXC) || (byte_data == FN_WRITE_EXC);
   assign idx_inc    = idx_ff + 9'd1;
   assign len_eff    = ((idx_ff == 9'd2) && (func_ff == FN_READ)) ?
                       READ_OVERHEAD + {1'b0, byte_data} : len_ff;
   assign done       = (phase_ff == PH_BODY) && (idx_inc >= len_eff);

   always_comb begin
      if ((phase_ff == PH_BODY) || ((phase_ff == PH_ADDR) && supported)) begin
         crc_next = crc_update(crc_ff, byte_data);
      end else begin
         crc_next = crc_update(CRC_INIT, byte_data);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_EMPTY: phase_in = PH_ADDR;
            PH_ADDR:  phase_in = supported ? PH_BODY : PH_ADDR;
            PH_BODY:  phase_in = done ? PH_EMPTY : PH_BODY;
            default:  phase_in = PH_EMPTY;
         endcase
      end
   end

   always_comb begin
      addr_in  = addr_ff;
      func_in  = func_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      data_in  = data_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_ADDR: begin
               crc_in = crc_next;
               if (supported) begin
                  func_in = byte_data;
                  idx_in  = 9'd2;
                  if (byte_data == FN_READ) begin
                     len_in = 9'd0;
                  end else if (byte_data == FN_WRITE) begin
                     len_in = WRITE_FRAME_LEN;
                  end else begin
                     len_in = EXC_FRAME_LEN;
                  end
               end else begin
                  addr_in = byte_data;
                  idx_in  = 9'd1;
               end
            end
            PH_BODY: begin
               if (done) begin
                  addr_in  = 8'h00;
                  func_in  = 8'h00;
                  len_in   = 9'd0;
                  idx_in   = 9'd0;
                  crc_in   = CRC_INIT;
                  count_in = 8'h00;
                  data_in  = 16'h0000;
               end else begin
                  crc_in = crc_next;
                  idx_in = idx_inc;
                  len_in = len_eff;
                  if (idx_ff == 9'd2) begin
                     count_in = byte_data;
                  end else if ((idx_ff == 9'd3) || (idx_ff == 9'd4)) begin
                     data_in = {data_ff[7:0], byte_data};
                  end
               end
            end
            default: begin
               addr_in = byte_data;
               crc_in  = crc_next;
               idx_in  = 9'd1;
            end
         endcase
      end
   end

   always_comb begin
      push           = accept && done;
      frame.crc_ok   = (crc_next == 16'h0000);
      frame.address  = addr_ff;
      frame.func     = func_ff;
      frame.count    = (idx_ff == 9'd2) ? byte_data : count_ff;
      frame.data     = ((idx_ff == 9'd3) || (idx_ff == 9'd4)) ?
                       {data_ff[7:0], byte_data} : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EMPTY;
         addr_ff  <= 8'h00;
         func_ff  <= 8'h00;
         len_ff   <= 9'd0;
         idx_ff   <= 9'd0;
         crc_ff   <= CRC_INIT;
         count_ff <= 8'h00;
         data_ff  <= 16'h0000;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         count_ff <= count_in;
         data_ff  <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mrd_queue.sv =====
// Short queue of frame summaries between the parser and the output stage.
// Register storage with read and write pointers. Depends on mrd_pkg.
`default_nettype none

module mrd_queue
   import mrd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire frame_type push_frame,
   output logic           full,
   input  wire logic      pop,
   output logic           not_empty,
   output frame_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   frame_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = store_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mrd_back.sv =====
// Back part of the deframer: classifies queued frames into result words.
// Holds them in an output register until taken. Depends on mrd_pkg.
`default_nettype none

module mrd_back
   import mrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      frame_valid,
   input  wire frame_type frame,
   output logic           pop,
   mrd_rsp_if.source      rsp
);

   logic        valid_ff, valid_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  addr_ff;
   logic [7:0]  func_ff;
   logic [15:0] value_ff, value_in;
   logic [7:0]  exc_ff, exc_in;

   assign pop = frame_valid && (!valid_ff || rsp.ready);

   always_comb begin
      value_in = 16'h0000;
      exc_in   = 8'h00;
      if (!frame.crc_ok) begin
         kind_in = KIND_CRC_ERROR;
      end else if (frame.func == FN_WRITE) begin
         kind_in = KIND_WRITE_ACK;
      end else if (frame.func == FN_READ) begin
         if (frame.count == 8'd2) begin
            kind_in  = KIND_READ_VALUE;
            value_in = frame.data;
         end else begin
            kind_in = KIND_READ_FMT;
         end
      end else begin
         kind_in = KIND_EXCEPTION;
         exc_in  = frame.count;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         addr_ff  <= frame.address;
         func_ff  <= frame.func;
         value_ff <= value_in;
         exc_ff   <= exc_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.frame_kind     = kind_ff;
   assign rsp.slave_address  = addr_ff;
   assign rsp.function_code  = func_ff;
   assign rsp.register_value = value_ff;
   assign rsp.exception_code = exc_ff;

endmodule

`default_nettype wire

// ===== hdl/modbus_rtu_response_deframer.sv =====
// Top level of the Modbus RTU response deframer.
// Joins mrd_front, mrd_queue and mrd_back; depends on mrd_pkg and mrd_if.
//
//   channel   direction   word
//   req_ch    in          one received byte (rx_byte)
//   rsp_ch    out         one decoded frame (kind, address, function, value, exception)
//
// A byte is taken every cycle while the frame queue has room; a frame's
// summary enters the queue with its last byte, then the output register once that is free.
// The CRC update is one unrolled byte step, so the parser holds one byte a cycle while the queue has room.
// Reset is synchronous and empties the parser, the queue and the output register.
// A stalled output fills the queue, and only then is req_ch held off.
`default_nettype none

module modbus_rtu_response_deframer
   import mrd_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   mrd_req_if.sink   req_ch,
   mrd_rsp_if.source rsp_ch
);

   logic      queue_full;
   logic      push;
   frame_type push_frame;
   logic      pop;
   logic      queue_valid;
   frame_type head;

   mrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_ch.valid),
      .byte_data  (req_ch.rx_byte),
      .byte_ready (req_ch.ready),
      .queue_full (queue_full),
      .push       (push),
      .frame      (push_frame)
   );

   mrd_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_valid),
      .head       (head)
   );

   mrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (queue_valid),
      .frame       (head),
      .pop         (pop),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire
